// ===== rtl/core/oaht_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the open-address hash table.
package oaht_pkg;

	localparam int SLOTS         = 256;
	localparam int KEY_BYTES     = 8;
	localparam int PAYLOAD_BYTES = 8;
	localparam int SLOT_W        = $clog2(SLOTS);
	localparam int CAP_W         = $clog2(SLOTS + 1);
	localparam int SUM_W         = $clog2(KEY_BYTES * 255 + 1);
	localparam int DIV_STEPS     = (SUM_W + 1) / 2;
	localparam int DIV_W         = 2 * DIV_STEPS;
	localparam int DCNT_W        = $clog2(DIV_STEPS + 1);

	localparam logic [1:0] CFG_CAPACITY = 2'd0;
	localparam logic [1:0] CFG_MAX_KEY  = 2'd1;
	localparam logic [1:0] CFG_MAX_PAY  = 2'd2;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_GET    = 2'd2,
		ACT_UPDATE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		RSP_OK       = 3'd0,
		RSP_FULL     = 3'd1,
		RSP_BADLEN   = 3'd2,
		RSP_EXISTS   = 3'd3,
		RSP_NOTFOUND = 3'd4
	} rsp_code_t;

	typedef enum logic [1:0] {
		ST_EMPTY   = 2'd0,
		ST_LIVE    = 2'd1,
		ST_DELETED = 2'd2
	} slot_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key_bytes;
		logic [3:0]  key_length;
		logic [63:0] payload_bytes;
		logic [3:0]  payload_length;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] found_payload;
		logic [3:0]  found_payload_length;
		logic [7:0]  slot_index;
		logic [8:0]  entry_count;
	} rsp_t;

	typedef struct packed {
		logic      capture;
		logic      div_start;
		logic      div_step;
		logic      rd_issue;
		logic      probe_next;
		logic      wr_insert;
		logic      wr_delete;
		logic      wr_update;
		logic      set_code;
		rsp_code_t code;
		logic      res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic        pre_hit;
		rsp_code_t   pre_code;
		logic        div_done;
		slot_state_t slot_state;
		logic        key_match;
		logic        probe_last;
		action_t     action;
		logic        rsp_busy;
	} dp_stat_t;

	typedef struct packed {
		logic [SLOT_W-1:0] six;
		logic [SLOT_W-1:0] eight;
		logic [SLOT_W-1:0] fourteen;
	} step_seed_t;

	function automatic logic [63:0] byte_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (4'(b) < len) begin
				m[8*b +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	function automatic logic [SLOT_W-1:0] mod_add(input logic [SLOT_W-1:0] a,
			input logic [SLOT_W-1:0] b, input logic [CAP_W-1:0] cap);
		logic [CAP_W:0] s;
		s = {2'b00, a} + {2'b00, b};
		if (s >= {1'b0, cap}) begin
			s = s - {1'b0, cap};
		end
		return s[SLOT_W-1:0];
	endfunction

	function automatic step_seed_t step_seed(input logic [CAP_W-1:0] cap);
		step_seed_t r;
		unique case (cap)
			CAP_W'(1):  r = '{SLOT_W'(0), SLOT_W'(0), SLOT_W'(0)};
			CAP_W'(2):  r = '{SLOT_W'(0), SLOT_W'(0), SLOT_W'(0)};
			CAP_W'(3):  r = '{SLOT_W'(0), SLOT_W'(2), SLOT_W'(2)};
			CAP_W'(4):  r = '{SLOT_W'(2), SLOT_W'(0), SLOT_W'(2)};
			CAP_W'(5):  r = '{SLOT_W'(1), SLOT_W'(3), SLOT_W'(4)};
			CAP_W'(6):  r = '{SLOT_W'(0), SLOT_W'(2), SLOT_W'(2)};
			CAP_W'(7):  r = '{SLOT_W'(6), SLOT_W'(1), SLOT_W'(0)};
			CAP_W'(8):  r = '{SLOT_W'(6), SLOT_W'(0), SLOT_W'(6)};
			CAP_W'(9):  r = '{SLOT_W'(6), SLOT_W'(8), SLOT_W'(5)};
			CAP_W'(10): r = '{SLOT_W'(6), SLOT_W'(8), SLOT_W'(4)};
			CAP_W'(11): r = '{SLOT_W'(6), SLOT_W'(8), SLOT_W'(3)};
			CAP_W'(12): r = '{SLOT_W'(6), SLOT_W'(8), SLOT_W'(2)};
			CAP_W'(13): r = '{SLOT_W'(6), SLOT_W'(8), SLOT_W'(1)};
			CAP_W'(14): r = '{SLOT_W'(6), SLOT_W'(8), SLOT_W'(0)};
			CAP_W'(15): r = '{SLOT_W'(6), SLOT_W'(8), SLOT_W'(14)};
			default:    r = '{SLOT_W'(6), SLOT_W'(8), SLOT_W'(14)};
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/oaht_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the open-address hash table.
module oaht_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  oaht_pkg::dp_stat_t stat,
	output oaht_pkg::dp_cmd_t  cmd
);
	import oaht_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PREP  = 6'b000010,
		S_DIV   = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_PREP;
				end
			end
			S_PREP: begin
				if (stat.pre_hit) begin
					cmd.set_code = 1'b1;
					cmd.code     = stat.pre_code;
					state_d      = S_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_CHECK;
			end
			S_CHECK: begin
				cmd.set_code = 1'b1;
				state_d      = S_DONE;
				if (stat.action == ACT_INSERT) begin
					priority if (stat.slot_state != ST_LIVE) begin
						cmd.wr_insert = 1'b1;
						cmd.code      = RSP_OK;
					end else if (stat.key_match) begin
						cmd.code = RSP_EXISTS;
					end else if (stat.probe_last) begin
						cmd.code = RSP_FULL;
					end else begin
						cmd.set_code   = 1'b0;
						cmd.probe_next = 1'b1;
						state_d        = S_READ;
					end
				end else begin
					priority if (stat.slot_state == ST_EMPTY) begin
						cmd.code = RSP_NOTFOUND;
					end else if (stat.slot_state == ST_LIVE && stat.key_match) begin
						cmd.code      = RSP_OK;
						cmd.wr_delete = (stat.action == ACT_DELETE);
						cmd.wr_update = (stat.action == ACT_UPDATE);
					end else if (stat.probe_last) begin
						cmd.code = RSP_NOTFOUND;
					end else begin
						cmd.set_code   = 1'b0;
						cmd.probe_next = 1'b1;
						state_d        = S_READ;
					end
				end
			end
			S_DONE: begin
				if (!stat.rsp_busy) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/oaht_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the open-address hash table: request, probe arithmetic, slot stores, result.
module oaht_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  oaht_pkg::dp_cmd_t  cmd,
	output oaht_pkg::dp_stat_t stat,
	input  oaht_pkg::req_t     req,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [8:0]         cfg_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output oaht_pkg::rsp_t     rsp
);
	import oaht_pkg::*;

	logic [CAP_W-1:0]  cap_q;
	logic [3:0]        mk_q, mp_q;
	req_t              req_q;
	logic [CAP_W-1:0]  count_q;
	logic [DIV_W-1:0]  div_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [SLOT_W-1:0] j_q, a_q, u_q;
	logic [CAP_W-1:0]  i_q;
	rsp_code_t         code_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic [63:0]       key_mem [SLOTS];
	logic [3:0]        klen_mem [SLOTS];
	logic [63:0]       pay_mem [SLOTS];
	logic [3:0]        plen_mem [SLOTS];
	logic [1:0]        st_mem [SLOTS];
	logic              valid_q [SLOTS];

	logic [63:0]       rd_key_q, rd_pay_q;
	logic [3:0]        rd_klen_q, rd_plen_q;
	logic [1:0]        rd_st_q;
	logic              rd_vld_q;

	logic [SUM_W-1:0]  sum;
	logic              key_ok, pay_ok;
	step_seed_t        seed;
	logic [CAP_W-1:0]  t1, t2;
	logic [SLOT_W-1:0] r1, r2;
	slot_state_t       slot_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(SLOTS);
			mk_q  <= 4'(KEY_BYTES);
			mp_q  <= 4'(PAYLOAD_BYTES);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CAPACITY: begin
					if (cfg_data == '0) begin
						cap_q <= CAP_W'(1);
					end else if (32'(cfg_data) > SLOTS) begin
						cap_q <= CAP_W'(SLOTS);
					end else begin
						cap_q <= CAP_W'(cfg_data);
					end
				end
				CFG_MAX_KEY: begin
					mk_q <= (cfg_data[3:0] > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : cfg_data[3:0];
				end
				CFG_MAX_PAY: begin
					mp_q <= (cfg_data[3:0] > 4'(PAYLOAD_BYTES)) ?
						4'(PAYLOAD_BYTES) : cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q.action         <= req.action;
			req_q.key_bytes      <= req.key_bytes & byte_mask(req.key_length);
			req_q.key_length     <= req.key_length;
			req_q.payload_bytes  <= req.payload_bytes & byte_mask(req.payload_length);
			req_q.payload_length <= req.payload_length;
		end
	end

	always_comb begin
		sum = '0;
		for (int b = 0; b < KEY_BYTES; b++) begin
			sum = sum + SUM_W'(req_q.key_bytes[8*b +: 8]);
		end
	end

	assign key_ok = (req_q.key_length != '0) && (req_q.key_length <= mk_q);
	assign pay_ok = (req_q.payload_length != '0) && (req_q.payload_length <= mp_q);

	always_comb begin
		stat          = '0;
		stat.pre_hit  = 1'b0;
		stat.pre_code = RSP_OK;
		if (req_q.action == ACT_INSERT) begin
			priority if (count_q >= cap_q) begin
				stat.pre_hit  = 1'b1;
				stat.pre_code = RSP_FULL;
			end else if (!key_ok || !pay_ok) begin
				stat.pre_hit  = 1'b1;
				stat.pre_code = RSP_BADLEN;
			end
		end else begin
			priority if (!(key_ok && (req_q.action != ACT_UPDATE || pay_ok))) begin
				stat.pre_hit  = 1'b1;
				stat.pre_code = RSP_BADLEN;
			end else if (count_q == '0) begin
				stat.pre_hit  = 1'b1;
				stat.pre_code = RSP_NOTFOUND;
			end
		end
		stat.div_done   = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
		stat.slot_state = slot_state;
		stat.key_match  = (rd_klen_q == req_q.key_length) && (rd_key_q == req_q.key_bytes);
		stat.probe_last = ((i_q + CAP_W'(1)) == cap_q);
		stat.action     = action_t'(req_q.action);
		stat.rsp_busy   = rsp_valid_q && rsp_stall;
	end

	assign seed = step_seed(cap_q);
	assign t1   = {j_q, div_q[DIV_W-1]};
	assign r1   = (t1 >= cap_q) ? SLOT_W'(t1 - cap_q) : t1[SLOT_W-1:0];
	assign t2   = {r1, div_q[DIV_W-2]};
	assign r2   = (t2 >= cap_q) ? SLOT_W'(t2 - cap_q) : t2[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_q <= DIV_W'(sum);
			j_q   <= '0;
			a_q   <= seed.eight;
			u_q   <= seed.fourteen;
			i_q   <= '0;
		end else if (cmd.div_step) begin
			div_q <= {div_q[DIV_W-3:0], 2'b00};
			j_q   <= r2;
		end else if (cmd.probe_next) begin
			j_q <= mod_add(j_q, a_q, cap_q);
			a_q <= mod_add(a_q, u_q, cap_q);
			u_q <= mod_add(u_q, seed.six, cap_q);
			i_q <= i_q + CAP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_insert) begin
			key_mem[j_q]  <= req_q.key_bytes;
			klen_mem[j_q] <= req_q.key_length;
		end
		if (cmd.wr_insert || cmd.wr_update) begin
			pay_mem[j_q]  <= req_q.payload_bytes;
			plen_mem[j_q] <= req_q.payload_length;
		end
		if (cmd.wr_insert) begin
			st_mem[j_q] <= ST_LIVE;
		end else if (cmd.wr_delete) begin
			st_mem[j_q] <= ST_DELETED;
		end
		if (cmd.rd_issue) begin
			rd_key_q  <= key_mem[j_q];
			rd_klen_q <= klen_mem[j_q];
			rd_pay_q  <= pay_mem[j_q];
			rd_plen_q <= plen_mem[j_q];
			rd_st_q   <= st_mem[j_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				valid_q[k] <= 1'b0;
			end
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.wr_insert || cmd.wr_delete) begin
				valid_q[j_q] <= 1'b1;
			end
			if (cmd.rd_issue) begin
				rd_vld_q <= valid_q[j_q];
			end
		end
	end

	always_comb begin
		slot_state = ST_EMPTY;
		if (rd_vld_q) begin
			unique case (rd_st_q)
				ST_LIVE:    slot_state = ST_LIVE;
				ST_DELETED: slot_state = ST_DELETED;
				default:    slot_state = ST_EMPTY;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.wr_insert) begin
			count_q <= count_q + CAP_W'(1);
		end else if (cmd.wr_delete) begin
			count_q <= count_q - CAP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= RSP_OK;
		end else if (cmd.set_code) begin
			code_q <= cmd.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp_q.status               <= code_q;
			rsp_q.found_payload        <= '0;
			rsp_q.found_payload_length <= '0;
			rsp_q.slot_index           <= '0;
			rsp_q.entry_count          <= 9'(count_q);
			if (code_q == RSP_OK) begin
				rsp_q.slot_index <= 8'(j_q);
				if (req_q.action == ACT_GET) begin
					rsp_q.found_payload        <= rd_pay_q;
					rsp_q.found_payload_length <= rd_plen_q;
				end
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_insert |-> slot_state != ST_LIVE)
		else $error("insert into a live slot");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.probe_next |-> !stat.probe_last)
		else $error("probe past capacity");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_issue |-> {1'b0, j_q} < cap_q)
		else $error("probe slot out of range");

	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_delete |=> count_q == $past(count_q) - CAP_W'(1))
		else $error("entry count not decremented");

endmodule

// ===== rtl/core/open_address_hash_table_unit.sv =====
`timescale 1ns / 1ps
// Top level of the open-address hash table with tombstones and probing by quadratically growing steps.
// One request is handled at a time; each gives one response transaction. A request
// passes the accept register, the length and fill checks, the shift-subtract unit that
// reduces the key byte sum modulo capacity, a slot read and a compare against the
// registered read data for each probe, and the load of the response register; a request
// that a check rejects early skips the division and the probes.
// The response register frees the request side while a response waits to be taken.
// Configuration writes are always ready and must come only while the table is idle.
module open_address_hash_table_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  oaht_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output oaht_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [8:0]      cfg_data
);
	import oaht_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	oaht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	oaht_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the open-address hash table with a behavioral table predictor.
module tb;
	import oaht_pkg::*;

	localparam int TIMEOUT_CYCLES = 20000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	open_address_hash_table_unit uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [8:0]  capacity_reg;
	logic [3:0]  max_key_reg;
	logic [3:0]  max_pay_reg;
	slot_state_t tbl_state [SLOTS];
	logic [63:0] tbl_key [SLOTS];
	logic [3:0]  tbl_klen [SLOTS];
	logic [63:0] tbl_pay [SLOTS];
	logic [3:0]  tbl_plen [SLOTS];
	int unsigned live_entries;

	rsp_t expected_rsps[$];
	int   fail_count;
	int   idle_cycles;
	int   rsp_hold_cycles;
	bit   random_stall;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] len_mask(input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (b < len) m[8*b +: 8] = 8'hFF;
		end
		return m;
	endfunction

	function automatic int unsigned table_cap();
		if (capacity_reg == 0) return 1;
		if (capacity_reg > SLOTS) return SLOTS;
		return capacity_reg;
	endfunction

	function automatic int unsigned probe_home(input logic [63:0] k, input logic [3:0] len,
			input int unsigned cap);
		int unsigned s;
		s = 0;
		for (int b = 0; b < 8; b++) begin
			if (b < len) s += k[8*b +: 8];
		end
		return s % cap;
	endfunction

	function automatic int unsigned probe_next(input int unsigned cur, input int unsigned i,
			input int unsigned cap);
		longint unsigned s;
		s = longint'(cur) + 5 * longint'(i) + 3 * longint'(i) * longint'(i);
		return int'(s % cap);
	endfunction

	function automatic rsp_t predict_table_rsp(input req_t r);
		rsp_t o;
		logic [63:0] k, p;
		int unsigned cap, mk, mp, j;
		bit key_ok, pay_ok, hit;
		o = '0;
		k = r.key_bytes & len_mask(r.key_length);
		p = r.payload_bytes & len_mask(r.payload_length);
		cap = table_cap();
		mk = (max_key_reg > KEY_BYTES) ? KEY_BYTES : max_key_reg;
		mp = (max_pay_reg > PAYLOAD_BYTES) ? PAYLOAD_BYTES : max_pay_reg;
		key_ok = r.key_length >= 1 && r.key_length <= mk;
		pay_ok = r.payload_length >= 1 && r.payload_length <= mp;
		o.status = RSP_OK;
		if (r.action == ACT_INSERT) begin
			if (live_entries >= cap) o.status = RSP_FULL;
			else if (!key_ok || !pay_ok) o.status = RSP_BADLEN;
			else begin
				o.status = RSP_FULL;
				j = probe_home(k, r.key_length, cap);
				for (int unsigned i = 0; i < cap; i++) begin
					if (tbl_state[j] != ST_LIVE) begin
						tbl_state[j] = ST_LIVE;
						tbl_key[j] = k;
						tbl_klen[j] = r.key_length;
						tbl_pay[j] = p;
						tbl_plen[j] = r.payload_length;
						live_entries++;
						o.status = RSP_OK;
						o.slot_index = j[7:0];
						break;
					end
					if (tbl_klen[j] == r.key_length && tbl_key[j] == k) begin
						o.status = RSP_EXISTS;
						break;
					end
					j = probe_next(j, i + 1, cap);
				end
			end
		end else if (!key_ok || (r.action == ACT_UPDATE && !pay_ok)) begin
			o.status = RSP_BADLEN;
		end else begin
			hit = 0;
			if (live_entries != 0) begin
				j = probe_home(k, r.key_length, cap);
				for (int unsigned i = 0; i < cap; i++) begin
					if (tbl_state[j] == ST_EMPTY) break;
					if (tbl_state[j] == ST_LIVE && tbl_klen[j] == r.key_length
							&& tbl_key[j] == k) begin
						hit = 1;
						break;
					end
					j = probe_next(j, i + 1, cap);
				end
			end
			if (!hit) o.status = RSP_NOTFOUND;
			else begin
				o.slot_index = j[7:0];
				if (r.action == ACT_DELETE) begin
					tbl_state[j] = ST_DELETED;
					live_entries--;
				end else if (r.action == ACT_GET) begin
					o.found_payload = tbl_pay[j];
					o.found_payload_length = tbl_plen[j];
				end else begin
					tbl_pay[j] = p;
					tbl_plen[j] = r.payload_length;
				end
			end
		end
		o.entry_count = live_entries[8:0];
		return o;
	endfunction

	task automatic send_request(input action_t act, input logic [63:0] k, input logic [3:0] kl,
			input logic [63:0] p, input logic [3:0] pl, input bit gaps);
		req_t r;
		int gap;
		r.action = act;
		r.key_bytes = k;
		r.key_length = kl;
		r.payload_bytes = p;
		r.payload_length = pl;
		gap = 0;
		if (gaps) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
			if ($urandom_range(0, 3) == 0) gap = 0;
		end
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		expected_rsps.push_back(predict_table_rsp(r));
	endtask

	task automatic drain_rsps();
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
		drain_rsps();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_CAPACITY) capacity_reg = val;
		else if (idx == CFG_MAX_KEY) max_key_reg = val[3:0];
		else max_pay_reg = val[3:0];
	endtask

	task automatic set_config(input logic [8:0] cap, input logic [3:0] mk, input logic [3:0] mp);
		write_reg(CFG_CAPACITY, cap);
		write_reg(CFG_MAX_KEY, {5'd0, mk});
		write_reg(CFG_MAX_PAY, {5'd0, mp});
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic test_directed();
		send_request(ACT_GET, 64'h1, 4'd1, 64'h0, 4'd1, 0);
		send_request(ACT_DELETE, 64'h1, 4'd1, 64'h0, 4'd1, 0);
		send_request(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 0);
		send_request(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h5, 4'd1, 0);
		send_request(ACT_INSERT, 64'hFF, 4'd1, 64'hAB, 4'd0, 0);
		send_request(ACT_INSERT, 64'hFF, 4'd0, 64'hAB, 4'd1, 0);
		send_request(ACT_INSERT, 64'hFF, 4'd9, 64'hAB, 4'd1, 0);
		send_request(ACT_INSERT, 64'hFF, 4'd15, 64'hAB, 4'd15, 0);
		send_request(ACT_INSERT, 64'hAAAA_0000_0000_00FF, 4'd1, 64'h1234_5678, 4'd2, 0);
		send_request(ACT_INSERT, 64'h00FF, 4'd2, 64'h77, 4'd1, 0);
		send_request(ACT_GET, 64'h55FF, 4'd1, 64'h0, 4'd0, 0);
		send_request(ACT_GET, 64'h00FF, 4'd2, 64'h0, 4'd0, 0);
		send_request(ACT_UPDATE, 64'hFF, 4'd1, 64'h9999, 4'd0, 0);
		send_request(ACT_UPDATE, 64'hFF, 4'd1, 64'h0, 4'd8, 0);
		send_request(ACT_GET, 64'hFF, 4'd1, 64'h0, 4'd3, 0);
		send_request(ACT_DELETE, 64'hFF, 4'd1, 64'h0, 4'd0, 0);
		send_request(ACT_GET, 64'hFF, 4'd1, 64'h0, 4'd0, 0);
		send_request(ACT_GET, 64'h00FF, 4'd2, 64'h0, 4'd0, 0);
		send_request(ACT_INSERT, 64'h00FF, 4'd2, 64'h1, 4'd1, 0);
		send_request(ACT_DELETE, 64'h0, 4'd0, 64'h0, 4'd0, 0);
		send_request(ACT_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0, 4'd0, 0);
	endtask

	task automatic test_small_tables();
		logic [8:0] caps [5];
		caps = '{9'd0, 9'd1, 9'd2, 9'd5, 9'd16};
		foreach (caps[c]) begin
			set_config(caps[c], 4'd2, 4'd2);
			repeat (30) run_random_op(3'd1, 1);
		end
	endtask

	task automatic run_random_op(input logic [2:0] key_space, input bit gaps);
		action_t act;
		logic [63:0] k;
		logic [3:0] kl, pl;
		act = action_t'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0) begin
			k = rand64();
			kl = 4'($urandom_range(0, 15));
			pl = 4'($urandom_range(0, 15));
		end else begin
			kl = 4'($urandom_range(1, 2));
			k = {$urandom(), $urandom()} & 64'hFF_FF;
			if (key_space == 1) k = k & 64'h0707;
			pl = 4'($urandom_range(1, 8));
		end
		send_request(act, k, kl, rand64(), pl, gaps);
	endtask

	task automatic test_random_mix();
		set_config(9'd256, 4'd8, 4'd8);
		for (int n = 0; n < 500; n++) run_random_op(3'd0, 1);
		set_config(9'd300, 4'd15, 4'd15);
		for (int n = 0; n < 300; n++) run_random_op(3'($urandom_range(0, 1)), 1);
		set_config(9'd37, 4'd8, 4'd8);
		for (int n = 0; n < 250; n++) run_random_op(3'd0, 1);
	endtask

	task automatic test_backpressure();
		set_config(9'd256, 4'd8, 4'd8);
		random_stall = 0;
		rsp_hold_cycles = 200;
		for (int n = 0; n < 40; n++) run_random_op(3'd0, 0);
		drain_rsps();
		random_stall = 1;
		for (int n = 0; n < 150; n++) run_random_op(3'd0, 1);
	endtask

	always @(posedge clk) begin
		if (rsp_hold_cycles > 0) begin
			rsp_hold_cycles <= rsp_hold_cycles - 1;
			rsp_stall <= 1'b1;
		end else if (random_stall) begin
			rsp_stall <= ($urandom_range(0, 15) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$error("response transaction with nothing expected");
				fail_count++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, rsp.status);
					fail_count++;
				end
				if (rsp.found_payload !== e.found_payload) begin
					$error("found_payload expected %h actual %h", e.found_payload,
						rsp.found_payload);
					fail_count++;
				end
				if (rsp.found_payload_length !== e.found_payload_length) begin
					$error("found_payload_length expected %0d actual %0d",
						e.found_payload_length, rsp.found_payload_length);
					fail_count++;
				end
				if (rsp.slot_index !== e.slot_index) begin
					$error("slot_index expected %0d actual %0d", e.slot_index, rsp.slot_index);
					fail_count++;
				end
				if (rsp.entry_count !== e.entry_count) begin
					$error("entry_count expected %0d actual %0d", e.entry_count,
						rsp.entry_count);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= TIMEOUT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		idle_cycles = 0;
		rsp_hold_cycles = 0;
		random_stall = 1;
		capacity_reg = 9'd256;
		max_key_reg = 4'd8;
		max_pay_reg = 4'd8;
		live_entries = 0;
		for (int s = 0; s < SLOTS; s++) begin
			tbl_state[s] = ST_EMPTY;
			tbl_key[s] = '0;
			tbl_klen[s] = '0;
			tbl_pay[s] = '0;
			tbl_plen[s] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_small_tables();
		test_random_mix();
		test_backpressure();
		drain_rsps();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== open_address_hash_table_unit.f =====
rtl/core/oaht_pkg.sv
rtl/core/oaht_ctrl.sv
rtl/core/oaht_datapath.sv
rtl/core/open_address_hash_table_unit.sv
tb/tb.sv
